FILE: src/gpf_pkg.sv
// Shared widths, register codes and item types for the gravity pair force block.
package gpf_pkg;

    // Default fraction bits, and the bound's reset value in whole units
    localparam int FRAC_BITS_DEF = 16;
    localparam int BOUND_UNITS   = 5;

    // Datapath widths
    localparam int CW    = 32;   // coordinate, mass and register width
    localparam int DW    = 33;   // coordinate difference magnitude
    localparam int SW    = 66;   // squared separation
    localparam int RW    = 33;   // integer square root of the separation
    localparam int R2W   = 66;   // separation squared
    localparam int DENW  = 99;   // separation cubed
    localparam int GMW   = 96;   // G * m1 * m2
    localparam int NUMW  = 128;  // G * m1 * m2 * |d|
    localparam int QW    = 32;   // quotient bits kept
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY = 2'd0,
        REG_BOUND   = 2'd1
    } t_reg_idx;

    // Classified pair handed from the front end to the force engine
    typedef struct packed {
        logic [SW-1:0]  s;
        logic [DW-1:0]  ax;
        logic [DW-1:0]  ay;
        logic           sx;
        logic           sy;
        logic           app;
        logic [GMW-1:0] gmm;
    } t_mid_item;

    // Finished result
    typedef struct packed {
        logic [CW-1:0] force_x;
        logic [CW-1:0] force_y;
        logic          applied;
        logic          clipped;
    } t_result;

endpackage

FILE: src/gpf_queue.sv
// Small register queue used between the front end, the force engine and the result port.
module gpf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;

    // Pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);

    // The surrounding logic never writes a full queue nor reads an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");

endmodule

FILE: src/gpf_front.sv
// Front end: takes a body pair, forms the separation terms and the mass product, and classifies it.
module gpf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic signed [31:0]    i_first_x,
    input  logic signed [31:0]    i_first_y,
    input  logic signed [31:0]    i_second_x,
    input  logic signed [31:0]    i_second_y,
    input  logic [31:0]           i_first_mass,
    input  logic [31:0]           i_second_mass,
    input  logic [31:0]           i_gravity,
    input  logic [63:0]           i_bound_sq,
    input  logic                  i_q_full,
    output logic                  o_full,
    output logic                  o_valid,
    output gpf_pkg::t_mid_item    o_item
);
    import gpf_pkg::*;

    logic [2:0]      r_v;
    logic            en;
    logic [DW-1:0]   dx, dy, ax, ay;

    logic [DW-1:0]   r1_ax, r1_ay;
    logic            r1_sx, r1_sy;
    logic [63:0]     r1_gm;
    logic [CW-1:0]   r1_m2;

    logic [SW-1:0]   r2_axsq, r2_aysq;
    logic [63:0]     r2_gml, r2_gmh;
    logic [DW-1:0]   r2_ax, r2_ay;
    logic            r2_sx, r2_sy;

    t_mid_item       r3_item, n3_item;

    // The three stages move together unless the last one cannot hand over.
    assign en     = !(r_v[2] && i_q_full);
    assign o_full = !en;

    // Differences and magnitudes straight from the request
    always_comb begin
        dx = {i_second_x[31], i_second_x} - {i_first_x[31], i_first_x};
        dy = {i_second_y[31], i_second_y} - {i_first_y[31], i_first_y};
        ax = dx[DW-1] ? (DW'(0) - dx) : dx;
        ay = dy[DW-1] ? (DW'(0) - dy) : dy;
    end

    // Sum of squares, bound test and full mass product
    always_comb begin
        n3_item     = '0;
        n3_item.s   = r2_axsq + r2_aysq;
        n3_item.app = (n3_item.s > {2'b00, i_bound_sq});
        n3_item.gmm = {32'b0, r2_gml} + {r2_gmh, 32'b0};
        n3_item.ax  = r2_ax;
        n3_item.ay  = r2_ay;
        n3_item.sx  = r2_sx;
        n3_item.sy  = r2_sy;
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[1:0], i_push};
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ax   <= ax;
            r1_ay   <= ay;
            r1_sx   <= dx[DW-1];
            r1_sy   <= dy[DW-1];
            r1_gm   <= i_gravity * i_first_mass;
            r1_m2   <= i_second_mass;

            r2_axsq <= r1_ax * r1_ax;
            r2_aysq <= r1_ay * r1_ay;
            r2_gml  <= r1_gm[31:0] * r1_m2;
            r2_gmh  <= r1_gm[63:32] * r1_m2;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;

            r3_item <= n3_item;
        end
    end

    assign o_valid = r_v[2];
    assign o_item  = r3_item;

endmodule

FILE: src/gpf_back.sv
// Force engine: square root, separation cube, numerators, two dividers and saturation.
module gpf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  gpf_pkg::t_mid_item  i_item,
    output logic                o_take,
    input  logic                i_out_full,
    output logic                o_valid,
    output gpf_pkg::t_result    o_res
);
    import gpf_pkg::*;

    localparam int NSQ  = RW;          // one result bit per square root stage
    localparam int ND   = QW;          // one quotient bit per divider stage
    localparam int NTOT = NSQ + 4 + ND + 1;

    typedef struct packed {
        t_mid_item      item;
        logic [RW-1:0]  res;
        logic [SW-1:0]  sq;
    } t_sq;

    typedef struct packed {
        logic [RW-1:0]  r;
        logic [R2W-1:0] r2;
        logic [64:0]    nx0, ny0;
        logic [63:0]    gmh;
        logic [DW-1:0]  ax, ay;
        logic           sx, sy, app;
    } t_m1;

    typedef struct packed {
        logic [RW-1:0]  r;
        logic [32:0]    r2h;
        logic [65:0]    pl;
        logic [96:0]    nx1, ny1;
        logic [31:0]    gmt;
        logic [DW-1:0]  ax, ay;
        logic           sx, sy, app;
    } t_m2;

    typedef struct packed {
        logic [DENW-1:0] den;
        logic [NUMW-1:0] nx, ny;
        logic            sx, sy, app;
    } t_m3;

    typedef struct packed {
        logic [NUMW-1:0] rx, ry;
        logic [QW-1:0]   qx, qy;
        logic [DENW-1:0] den;
        logic            ox, oy, sx, sy, app;
    } t_dv;

    logic [NTOT-1:0] r_v;
    logic            en;

    t_sq   w_sq [NSQ+1];
    t_sq   r_sq [NSQ];
    t_m1   r_m1, n_m1;
    t_m2   r_m2, n_m2;
    t_m3   r_m3, n_m3;
    t_dv   w_dv [ND+1];
    t_dv   r_dv [ND];
    t_dv   r_ov, n_ov;
    t_result r_res, n_res;

    logic [64:0] pm2x, pm2y, pm3x, pm3y;
    logic [65:0] ph;

    // Saturate one quotient to 32 bits and apply the sign: returns {clip, value}.
    function automatic logic [CW:0] f_sat(input logic [QW-1:0] q, input logic ovf,
                                          input logic neg);
        logic [CW-1:0] lim;
        logic [CW-1:0] v;
        logic          clip;
        lim  = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        clip = ovf || (q > lim);
        v    = clip ? lim : q;
        return {clip, neg ? (CW'(0) - v) : v};
    endfunction

    // Whole pipeline advances unless a finished result is held up.
    assign en     = !(r_v[NTOT-1] && i_out_full);
    assign o_take = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NTOT-2:0], i_valid};
        end
    end

    // Square root, one result bit a stage, keeping res squared alongside
    always_comb begin
        w_sq[0]      = '0;
        w_sq[0].item = i_item;
    end

    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        localparam int B = NSQ - 1 - j;
        logic [SW+1:0] test;
        logic          fits;
        t_sq           n_sq;

        always_comb begin
            test = {2'b00, w_sq[j].sq} + ({35'b0, w_sq[j].res} << (B + 1))
                 + ((SW+2)'(1) << (2 * B));
            fits = (test <= {2'b00, w_sq[j].item.s});
            n_sq = w_sq[j];
            if (fits) begin
                n_sq.sq  = test[SW-1:0];
                n_sq.res = w_sq[j].res | (RW'(1) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[j] <= n_sq;
            end
        end

        assign w_sq[j+1] = r_sq[j];
    end

    // Separation squared and the low numerator partial products
    always_comb begin
        n_m1     = '0;
        n_m1.r   = w_sq[NSQ].res;
        n_m1.r2  = w_sq[NSQ].res * w_sq[NSQ].res;
        n_m1.nx0 = w_sq[NSQ].item.gmm[31:0] * w_sq[NSQ].item.ax;
        n_m1.ny0 = w_sq[NSQ].item.gmm[31:0] * w_sq[NSQ].item.ay;
        n_m1.gmh = w_sq[NSQ].item.gmm[95:32];
        n_m1.ax  = w_sq[NSQ].item.ax;
        n_m1.ay  = w_sq[NSQ].item.ay;
        n_m1.sx  = w_sq[NSQ].item.sx;
        n_m1.sy  = w_sq[NSQ].item.sy;
        n_m1.app = w_sq[NSQ].item.app;
    end

    // Low half of the cube and the middle numerator partial products
    always_comb begin
        pm2x     = r_m1.gmh[31:0] * r_m1.ax;
        pm2y     = r_m1.gmh[31:0] * r_m1.ay;
        n_m2     = '0;
        n_m2.r   = r_m1.r;
        n_m2.r2h = r_m1.r2[65:33];
        n_m2.pl  = r_m1.r2[32:0] * r_m1.r;
        n_m2.nx1 = {32'b0, r_m1.nx0} + {pm2x, 32'b0};
        n_m2.ny1 = {32'b0, r_m1.ny0} + {pm2y, 32'b0};
        n_m2.gmt = r_m1.gmh[63:32];
        n_m2.ax  = r_m1.ax;
        n_m2.ay  = r_m1.ay;
        n_m2.sx  = r_m1.sx;
        n_m2.sy  = r_m1.sy;
        n_m2.app = r_m1.app;
    end

    // Complete cube and numerators
    always_comb begin
        ph       = r_m2.r2h * r_m2.r;
        pm3x     = r_m2.gmt * r_m2.ax;
        pm3y     = r_m2.gmt * r_m2.ay;
        n_m3     = '0;
        n_m3.den = {33'b0, r_m2.pl} + {ph, 33'b0};
        n_m3.nx  = {31'b0, r_m2.nx1} + {pm3x[63:0], 64'b0};
        n_m3.ny  = {31'b0, r_m2.ny1} + {pm3y[63:0], 64'b0};
        n_m3.sx  = r_m2.sx;
        n_m3.sy  = r_m2.sy;
        n_m3.app = r_m2.app;
    end

    // Quotients of 2^32 or more saturate whatever the sign
    always_comb begin
        n_ov     = '0;
        n_ov.rx  = r_m3.nx;
        n_ov.ry  = r_m3.ny;
        n_ov.den = r_m3.den;
        n_ov.ox  = ({3'b0, r_m3.nx} >= {r_m3.den, 32'b0});
        n_ov.oy  = ({3'b0, r_m3.ny} >= {r_m3.den, 32'b0});
        n_ov.sx  = r_m3.sx;
        n_ov.sy  = r_m3.sy;
        n_ov.app = r_m3.app;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_m3 <= n_m3;
            r_ov <= n_ov;
            r_res <= n_res;
        end
    end

    assign w_dv[0] = r_ov;

    // Restoring division, one quotient bit a stage for both components
    for (genvar k = 0; k < ND; k++) begin : g_div
        localparam int B = ND - 1 - k;
        logic [NUMW+2:0] dsh;
        logic            gx, gy;
        t_dv             n_dv;

        always_comb begin
            dsh  = {32'b0, w_dv[k].den} << B;
            gx   = ({3'b0, w_dv[k].rx} >= dsh);
            gy   = ({3'b0, w_dv[k].ry} >= dsh);
            n_dv = w_dv[k];
            if (gx) begin
                n_dv.rx    = w_dv[k].rx - dsh[NUMW-1:0];
                n_dv.qx[B] = 1'b1;
            end
            if (gy) begin
                n_dv.ry    = w_dv[k].ry - dsh[NUMW-1:0];
                n_dv.qy[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k] <= n_dv;
            end
        end

        assign w_dv[k+1] = r_dv[k];
    end

    // Saturation, sign and the not-applied case
    always_comb begin
        logic [CW:0] fx, fy;
        fx    = f_sat(w_dv[ND].qx, w_dv[ND].ox, w_dv[ND].sx);
        fy    = f_sat(w_dv[ND].qy, w_dv[ND].oy, w_dv[ND].sy);
        n_res = '0;
        if (w_dv[ND].app) begin
            n_res.force_x = fx[CW-1:0];
            n_res.force_y = fy[CW-1:0];
            n_res.applied = 1'b1;
            n_res.clipped = fx[CW] || fy[CW];
        end
    end

    assign o_valid = r_v[NTOT-1];
    assign o_res   = r_res;

    // A finished result that cannot leave stays in place.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NTOT-1] && i_out_full) |=> r_v[NTOT-1])
        else $error("finished result lost under stall");

endmodule

FILE: src/gravity_pair_force.sv
// Top level of the gravity pair force block: registers, front end, queues and force engine.
// A request accepted passes through 3 front stages, the decoupling queue, 70 engine stages
// and the result queue before it shows on the result ports.
// Throughput: one request per cycle unless a full queue stalls; the 33-stage square root and the
// two 32-stage dividers are fully pipelined. Results leave through a two-entry queue.
// Reset is synchronous: queues and valid bits clear, G returns to 1.0 and the bound to 5.0.
// No stores need clearing, so requests are taken in the first cycle after reset.
module gravity_pair_force #(
    parameter int FRAC_BITS = gpf_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [31:0]                 i_first_x,
    input  logic signed [31:0]                 i_first_y,
    input  logic signed [31:0]                 i_second_x,
    input  logic signed [31:0]                 i_second_y,
    input  logic [31:0]                        i_first_mass,
    input  logic [31:0]                        i_second_mass,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [31:0]                 o_force_x,
    output logic signed [31:0]                 o_force_y,
    output logic                               o_applied,
    output logic                               o_clipped,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    import gpf_pkg::*;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    logic [CW-1:0] r_gravity, r_bound;
    logic [63:0]   r_bound_sq;

    logic          fr_valid, mid_full, mid_empty, mid_pop;
    t_mid_item     fr_item, mid_item;
    logic          bk_valid, out_full;
    t_result       bk_res, out_res;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= CW'(64'd1 << FRAC_BITS);
            r_bound   <= CW'(64'(BOUND_UNITS) << FRAC_BITS);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GRAVITY: r_gravity <= i_cfg_data;
                REG_BOUND:   r_bound   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Bound squared, kept ready for the separation test
    always_ff @(posedge i_clk) begin
        r_bound_sq <= r_bound * r_bound;
    end

    gpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .i_first_mass (i_first_mass),
        .i_second_mass(i_second_mass),
        .i_gravity    (r_gravity),
        .i_bound_sq   (r_bound_sq),
        .i_q_full     (mid_full),
        .o_full       (full),
        .o_valid      (fr_valid),
        .o_item       (fr_item)
    );

    // Decoupling queue between classification and the force engine
    gpf_queue #(
        .WIDTH($bits(t_mid_item)),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (fr_valid && !mid_full),
        .i_data (fr_item),
        .i_pop  (mid_pop),
        .o_data (mid_item),
        .o_full (mid_full),
        .o_empty(mid_empty)
    );

    gpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!mid_empty),
        .i_item    (mid_item),
        .o_take    (mid_pop),
        .i_out_full(out_full),
        .o_valid   (bk_valid),
        .o_res     (bk_res)
    );

    // Result queue facing the consumer
    gpf_queue #(
        .WIDTH($bits(t_result)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (bk_valid && !out_full),
        .i_data (bk_res),
        .i_pop  (pop && !empty),
        .o_data (out_res),
        .o_full (out_full),
        .o_empty(empty)
    );

    assign o_force_x = out_res.force_x;
    assign o_force_y = out_res.force_y;
    assign o_applied = out_res.applied;
    assign o_clipped = out_res.clipped;

    // A pair within the bound gives no force and no saturation.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_applied) |-> (o_force_x == '0 && o_force_y == '0 && !o_clipped))
        else $error("force reported for a pair within the bound");

endmodule
